>>> hw/rtl/bspf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspf_pkg
// Shared types, constants and helper functions for the battery
// state-of-charge percentage filter.
// ----------------------------------------------------------------------------
package bspf_pkg;

  // Scaling models selected by the configuration register.
  typedef enum logic {
    MODEL_FULL_WORD = 1'b0,
    MODEL_HIGH_BYTE = 1'b1
  } model_t;

  // Full-word scaling: t = soc * SocMul / SocDiv, percent = t / 100.
  localparam int unsigned SocMul   = 19531;
  localparam int unsigned SocDiv   = 96000;
  localparam int unsigned SocFullT = 10000;

  // The two floors collapse into one: percent = floor(soc * SocMul / (SocDiv * 100)).
  // A ceiling reciprocal with 40 fraction bits keeps that exact for all 16-bit words.
  localparam int unsigned SocRecipShift = 40;
  localparam logic [63:0] SocDivPct     = 64'(SocDiv) * 64'd100;
  localparam logic [31:0] SocRecip      =
    32'(((64'(SocMul) << SocRecipShift) + SocDivPct - 64'd1) / SocDivPct);

  // Smallest word for which t exceeds the full-scale value.
  localparam logic [63:0] SocFullProd = (64'(SocFullT) + 64'd1) * 64'(SocDiv);
  localparam logic [15:0] SocFullMin  =
    16'((SocFullProd + 64'(SocMul) - 64'd1) / 64'(SocMul));

  // High-byte scaling by 100/96.
  localparam logic [7:0] HiByteCap  = 8'd96;
  localparam logic [7:0] HiByteStep = 8'd24;

  localparam logic [6:0]  MaxPercent   = 7'd100;
  localparam logic [6:0]  LiftPercent  = 7'd1;
  localparam logic [2:0]  ZeroRunLimit = 3'd5;
  localparam logic [1:0]  StepsReset   = 2'd3;
  localparam logic [11:0] ThreshReset  = 12'd3250;

  // Result of the scaling stage handed to the filter state.
  typedef struct packed {
    logic [6:0] percent;   // scaled and capped percent
    logic       zero_hit;  // full-word model produced zero
  } scale_t;

  // Threshold increment in mV for a given number of steps left.
  function automatic logic [11:0] thresh_step(input logic [1:0] steps_left);
    logic [11:0] step;
    case (steps_left)
      2'd3:    step = 12'd100;
      2'd2:    step = 12'd50;
      2'd1:    step = 12'd20;
      default: step = 12'd0;
    endcase
    return step;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bspf_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspf_ifs
// Valid/ready channels for fuel-gauge samples and filtered percentages.
// ----------------------------------------------------------------------------
interface bspf_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] soc_raw;
  logic [11:0] vcell_raw;
  logic        read_ok;
  logic        charger_present;

  modport source (output valid, soc_raw, vcell_raw, read_ok, charger_present, input ready);
  modport sink   (input valid, soc_raw, vcell_raw, read_ok, charger_present, output ready);
endinterface

interface bspf_pct_if;
  logic       valid;
  logic       ready;
  logic [6:0] capacity_percent;

  modport source (output valid, capacity_percent, input ready);
  modport sink   (input valid, capacity_percent, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bspf_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspf_scale
// Converts the raw state-of-charge word to a capped percentage under the
// selected model.
// ----------------------------------------------------------------------------
module bspf_scale
  import bspf_pkg::*;
(
  input  model_t      model,
  input  logic [15:0] soc_raw,
  output scale_t      scale
);

  logic [47:0] prod;
  logic [6:0]  pct_full;
  logic [7:0]  hi;
  logic [6:0]  pct_hi;
  logic [1:0]  hi_extra;

  // One constant multiply; the quotient sits above the fraction bits.
  assign prod     = 48'(soc_raw) * 48'(SocRecip);
  assign pct_full = (soc_raw >= SocFullMin) ? MaxPercent
                                            : prod[SocRecipShift +: 7];

  // hi * 25 / 24 below the cap equals hi + hi / 24, and hi / 24 is at most 3.
  assign hi       = soc_raw[15:8];
  assign hi_extra = 2'(hi >= 8'(3 * HiByteStep)) + 2'(hi >= 8'(2 * HiByteStep))
                  + 2'(hi >= HiByteStep);
  assign pct_hi   = (hi >= HiByteCap) ? MaxPercent : 7'(hi) + 7'(hi_extra);

  always_comb begin
    if (model == MODEL_FULL_WORD) begin
      scale.percent  = pct_full;
      scale.zero_hit = (pct_full == 7'd0);
    end else begin
      scale.percent  = pct_hi;
      scale.zero_hit = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bspf_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspf_state
// Low-voltage lift, adaptive threshold and charger hold filter, with the
// state registers they keep between samples.
// ----------------------------------------------------------------------------
module bspf_state
  import bspf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        update,
  input  scale_t      scale,
  input  logic [11:0] vcell_raw,
  input  logic        read_ok,
  input  logic        charger_present,
  output logic [6:0]  percent
);

  logic [6:0]  previous_percent, previous_percent_next;
  logic [2:0]  zero_run_count, zero_run_count_next;
  logic [1:0]  steps_left, steps_left_next;
  logic [11:0] threshold_mv, threshold_mv_next;

  logic [14:0] vcell_x5;
  logic [12:0] vcell_mv;
  logic [6:0]  lifted;

  // 1.25 mV per code: mv = code * 5 / 4.
  assign vcell_x5 = 15'(vcell_raw) * 15'd5;
  assign vcell_mv = vcell_x5[14:2];

  always_comb begin
    previous_percent_next = previous_percent;
    zero_run_count_next   = zero_run_count;
    steps_left_next       = steps_left;
    threshold_mv_next     = threshold_mv;
    lifted                = scale.percent;
    percent               = previous_percent;

    if (read_ok) begin
      if (scale.zero_hit) begin
        if (vcell_mv > {1'b0, threshold_mv}) begin
          lifted = LiftPercent;
        end
        if (zero_run_count < ZeroRunLimit) begin
          zero_run_count_next = zero_run_count + 3'd1;
        end else if (steps_left != 2'd0) begin
          zero_run_count_next = 3'd0;
          threshold_mv_next   = threshold_mv + thresh_step(steps_left);
          steps_left_next     = steps_left - 2'd1;
        end
      end
      // Without a charger the reading is never allowed to climb.
      if (!charger_present && (previous_percent < lifted)) begin
        percent = previous_percent;
      end else begin
        percent               = lifted;
        previous_percent_next = lifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_percent <= MaxPercent;
      zero_run_count   <= 3'd0;
      steps_left       <= StepsReset;
      threshold_mv     <= ThreshReset;
    end else if (update) begin
      previous_percent <= previous_percent_next;
      zero_run_count   <= zero_run_count_next;
      steps_left       <= steps_left_next;
      threshold_mv     <= threshold_mv_next;
    end
  end

`ifndef SYNTHESIS
  a_prev_in_range: assert property (@(posedge clk) disable iff (rst)
    previous_percent <= MaxPercent)
    else $error("previous percent out of range");

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    zero_run_count <= ZeroRunLimit)
    else $error("zero run count beyond limit");

  a_thresh_moves_with_step: assert property (@(posedge clk) disable iff (rst)
    (threshold_mv != $past(threshold_mv)) |-> (steps_left == 2'($past(steps_left) - 2'd1)))
    else $error("threshold moved without a step");

  a_no_rise_offline: assert property (@(posedge clk) disable iff (rst)
    (update && read_ok && !charger_present) |=> (previous_percent <= $past(previous_percent)))
    else $error("percent rose without a charger");

  a_failed_read_holds: assert property (@(posedge clk) disable iff (rst)
    (update && !read_ok) |=> ($stable(previous_percent) && $stable(zero_run_count)
                              && $stable(threshold_mv)))
    else $error("state changed on a failed read");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/battery_soc_percent_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_soc_percent_filter
// Turns fuel-gauge samples into a filtered battery capacity percentage.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                         Width
//   sample    in         soc_raw, vcell_raw, read_ok, charger_present   16/12/1/1
//   result    out        capacity_percent                                7
//   cfg       in         cfg_write_en, cfg_write_data (battery_model)    1
//
// While result is not stalled, one sample is taken every cycle; each transfer
// on sample yields exactly one result transfer, via the input then the result register. The
// per-sample cost is set by the single constant multiply in the scaling path
// and the filter state update, both done between the input register and the
// result register. Reset is synchronous and restores the filter state
// (previous 100 %, threshold 3250 mV, three threshold steps) and model 0.
// A stall on result holds the result register; the input register keeps
// accepting until it too holds an item, then sample.ready drops.
//
module battery_soc_percent_filter
  import bspf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic         cfg_write_data,
  bspf_sample_if.sink  sample,
  bspf_pct_if.source   result
);

  // Configuration: written only while the block is idle (user rule, unchecked).
  model_t battery_model;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_model <= MODEL_FULL_WORD;
    end else if (cfg_write_en) begin
      battery_model <= model_t'(cfg_write_data);
    end
  end

  // Input register. The payload is loaded on every transfer; only the valid
  // flag needs a reset.
  logic        in_valid;
  logic [15:0] in_soc;
  logic [11:0] in_vcell;
  logic        in_ok;
  logic        in_chg;

  // Result register.
  logic        out_valid;
  logic [6:0]  out_percent;

  // The item in the input register moves into the result register, and the
  // filter state commits, whenever the result register is free or draining.
  logic advance;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_soc   <= sample.soc_raw;
      in_vcell <= sample.vcell_raw;
      in_ok    <= sample.read_ok;
      in_chg   <= sample.charger_present;
    end
  end

  // Scaling and filtering of the registered sample.
  scale_t     scale;
  logic [6:0] filtered;

  bspf_scale u_scale (
    .model   (battery_model),
    .soc_raw (in_soc),
    .scale   (scale)
  );

  bspf_state u_state (
    .clk             (clk),
    .rst             (rst),
    .update          (advance),
    .scale           (scale),
    .vcell_raw       (in_vcell),
    .read_ok         (in_ok),
    .charger_present (in_chg),
    .percent         (filtered)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_percent <= filtered;
    end
  end

  assign result.valid            = out_valid;
  assign result.capacity_percent = out_percent;

endmodule
`default_nettype wire
